### rtl/rea_pkg.sv
// Shared types and constants for the ring elementary automaton.
`default_nettype none
package rea_pkg;

    // Ring geometry.
    localparam int NUM_CELLS = 256;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = (NUM_CELLS + WORD_W - 1) / WORD_W;
    localparam int SNAP_W    = NUM_WORDS * WORD_W;
    localparam int CNT_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Live cells of the seed that ends every rule period.
    localparam int SEED_A = NUM_CELLS / 2;
    localparam int SEED_B = (NUM_CELLS / 2 + NUM_CELLS / 3) % NUM_CELLS;
    localparam int SEED_C = (NUM_CELLS / 2 + NUM_CELLS - NUM_CELLS / 3) % NUM_CELLS;

    // Ring after reset: only the center cell is live.
    localparam logic [NUM_CELLS-1:0] CENTER_RING = NUM_CELLS'(1) << SEED_A;

    // Field widths.
    localparam int FRAME_W = 31;
    localparam int REG_W   = 8;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int NUM_RULES = 6;

    // Register reset values.
    localparam logic [REG_W-1:0] RULE_A_RST = 8'd90;
    localparam logic [REG_W-1:0] RULE_B_RST = 8'd150;
    localparam logic [REG_W-1:0] RULE_C_RST = 8'd18;
    localparam logic [REG_W-1:0] RULE_D_RST = 8'd22;
    localparam logic [REG_W-1:0] RULE_E_RST = 8'd126;
    localparam logic [REG_W-1:0] RULE_F_RST = 8'd182;
    localparam logic [REG_W-1:0] GENS_RST   = 8'd96;
    localparam logic [REG_W-1:0] FPG_RST    = 8'd5;

    // Last rule slot before wrapping back to the first.
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_RULES - 1);

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_RULE_A = 3'd0,
        REG_RULE_B = 3'd1,
        REG_RULE_C = 3'd2,
        REG_RULE_D = 3'd3,
        REG_RULE_E = 3'd4,
        REG_RULE_F = 3'd5,
        REG_GENS   = 3'd6,
        REG_FPG    = 3'd7
    } cfg_reg_t;

    // Register file contents seen by the generation logic.
    typedef struct packed {
        logic [NUM_RULES-1:0][REG_W-1:0] rules;
        logic [REG_W-1:0]                gens_per_rule;
        logic [REG_W-1:0]                frames_per_gen;
    } cfg_t;

    // Frame result handed from the generation logic to the serializer.
    typedef struct packed {
        logic              load;
        logic              advanced;
        logic [SNAP_W-1:0] ring;
    } frame_res_t;

endpackage
`default_nettype wire

### rtl/rea_cfg.sv
// Configuration register file for the ring elementary automaton.
`default_nettype none
module rea_cfg
    import rea_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes, one per transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rules[0]       <= RULE_A_RST;
            cfg_reg.rules[1]       <= RULE_B_RST;
            cfg_reg.rules[2]       <= RULE_C_RST;
            cfg_reg.rules[3]       <= RULE_D_RST;
            cfg_reg.rules[4]       <= RULE_E_RST;
            cfg_reg.rules[5]       <= RULE_F_RST;
            cfg_reg.gens_per_rule  <= GENS_RST;
            cfg_reg.frames_per_gen <= FPG_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RULE_A: cfg_reg.rules[0]       <= cfg_data;
                REG_RULE_B: cfg_reg.rules[1]       <= cfg_data;
                REG_RULE_C: cfg_reg.rules[2]       <= cfg_data;
                REG_RULE_D: cfg_reg.rules[3]       <= cfg_data;
                REG_RULE_E: cfg_reg.rules[4]       <= cfg_data;
                REG_RULE_F: cfg_reg.rules[5]       <= cfg_data;
                REG_GENS:   cfg_reg.gens_per_rule  <= cfg_data;
                REG_FPG:    cfg_reg.frames_per_gen <= cfg_data;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/rea_ring.sv
// Cell ring, rule sequencing and one-generation update logic.
`default_nettype none
module rea_ring
    import rea_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire cfg_t               cfg,
    output frame_res_t              res
);

    logic [NUM_CELLS-1:0] cells_reg;
    logic [NUM_CELLS-1:0] cells_next;
    logic [NUM_CELLS-1:0] stepped;
    logic [NUM_CELLS-1:0] seed;
    logic [REG_W-1:0]     phase_reg;
    logic [REG_W-1:0]     phase_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [FRAME_W-1:0]   last_frame_reg;
    logic                 has_adv_reg;
    logic [REG_W-1:0]     rule;
    logic [REG_W-1:0]     period_m1;
    logic [FRAME_W-1:0]   frame_delta;
    logic                 adv;
    logic                 reseed;

    // Rule of the active slot.
    always_comb begin
        unique case (slot_reg)
            3'd0:    rule = cfg.rules[0];
            3'd1:    rule = cfg.rules[1];
            3'd2:    rule = cfg.rules[2];
            3'd3:    rule = cfg.rules[3];
            3'd4:    rule = cfg.rules[4];
            default: rule = cfg.rules[5];
        endcase
    end

    // Each cell looks up its neighborhood in the rule; neighbors wrap around.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        localparam int LEFT  = (i + NUM_CELLS - 1) % NUM_CELLS;
        localparam int RIGHT = (i + 1) % NUM_CELLS;
        assign stepped[i] = rule[{cells_reg[LEFT], cells_reg[i], cells_reg[RIGHT]}];
    end

    // Seed pattern that replaces the ring at the end of a rule period.
    always_comb begin
        seed         = '0;
        seed[SEED_A] = 1'b1;
        seed[SEED_B] = 1'b1;
        seed[SEED_C] = 1'b1;
    end

    // Advance decision: first frame, frame stepped back, or enough frames passed.
    assign frame_delta = frame - last_frame_reg;
    assign adv = !has_adv_reg || (frame < last_frame_reg)
              || (frame_delta >= FRAME_W'(cfg.frames_per_gen));

    // A zero period counts as one generation.
    assign period_m1 = (cfg.gens_per_rule == '0) ? '0 : cfg.gens_per_rule - 8'd1;
    assign reseed    = (phase_reg >= period_m1);

    // Next generation, phase and rule slot.
    always_comb begin
        if (reseed) begin
            cells_next = seed;
            phase_next = '0;
            slot_next  = (slot_reg >= LAST_SLOT) ? '0 : slot_reg + 3'd1;
        end else begin
            cells_next = stepped;
            phase_next = phase_reg + 8'd1;
            slot_next  = slot_reg;
        end
    end

    // State update on each accepted transaction that advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg      <= CENTER_RING;
            phase_reg      <= '0;
            slot_reg       <= '0;
            last_frame_reg <= '0;
            has_adv_reg    <= 1'b0;
        end else if (accept && adv) begin
            cells_reg      <= cells_next;
            phase_reg      <= phase_next;
            slot_reg       <= slot_next;
            last_frame_reg <= frame;
            has_adv_reg    <= 1'b1;
        end
    end

    // Newest ring for this frame goes to the serializer.
    assign res.load     = accept;
    assign res.advanced = adv;
    assign res.ring     = adv ? SNAP_W'(cells_next) : SNAP_W'(cells_reg);

endmodule
`default_nettype wire

### rtl/rea_serializer.sv
// Result register that emits one frame's ring as a run of 64-bit words.
`default_nettype none
module rea_serializer
    import rea_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire frame_res_t  res,
    output logic             free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_word_index,
    output logic [WORD_W-1:0] m_cells_word,
    output logic             m_advanced,
    output logic             m_last_word
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SNAP_W-1:0] snap_reg;
    logic              adv_reg;
    logic              last;
    logic              taken;

    assign last  = (cnt_reg == CNT_W'(NUM_WORDS - 1));
    assign taken = busy_reg && m_ready;
    // A new frame may load while the final word of the previous one is taken.
    assign free  = !busy_reg || (m_ready && last);

    // Word counter and run control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (res.load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (taken) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Frame snapshot, held for the whole run.
    always_ff @(posedge aclk) begin
        if (res.load) begin
            snap_reg <= res.ring;
            adv_reg  <= res.advanced;
        end
    end

    // Output word selection.
    assign m_valid      = busy_reg;
    assign m_word_index = 2'(cnt_reg);
    assign m_cells_word = snap_reg[cnt_reg * WORD_W +: WORD_W];
    assign m_advanced   = adv_reg;
    assign m_last_word  = last;

endmodule
`default_nettype wire

### rtl/ring_elementary_automaton_top.sv
// Top level of the ring elementary automaton.
//
// Each accepted frame number may advance a 256-cell periodic elementary
// automaton by one generation; the whole ring is updated in the cycle the frame
// transaction is accepted. The frame's result is four 64-bit words, the first
// valid in the cycle after acceptance and one per cycle after that while
// m_ready is high, so the word serializer sets the sustained frame rate. The
// next frame is accepted in the same cycle its predecessor's last word is
// taken. The ring is ready straight out of reset with only cell 128 live.
// Configuration writes are taken in every cycle and must be made only while
// no frame is in flight.
`default_nettype none
module ring_elementary_automaton_top
    import rea_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FRAME_W-1:0] s_frame_number,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_word_index,
    output logic [WORD_W-1:0]       m_cells_word,
    output logic                    m_advanced,
    output logic                    m_last_word,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [REG_W-1:0]   cfg_data
);

    cfg_t       cfg;
    frame_res_t res;
    logic       free;

    // Input acceptance follows the serializer's room.
    assign s_ready = free;

    // Register file.
    rea_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Generation logic.
    rea_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_valid && free),
        .frame   (s_frame_number),
        .cfg     (cfg),
        .res     (res)
    );

    // Output word serializer.
    rea_serializer u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res          (res),
        .free         (free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_cells_word (m_cells_word),
        .m_advanced   (m_advanced),
        .m_last_word  (m_last_word)
    );

endmodule
`default_nettype wire

### rtl/rea_checker.sv
// Port-level checker for the ring elementary automaton, bound to the top level.
`default_nettype none
module rea_checker
    import rea_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_word_index,
    input wire logic [WORD_W-1:0]  m_cells_word,
    input wire logic               m_advanced,
    input wire logic               m_last_word
);

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cells_word)
            && $stable(m_word_index) && $stable(m_last_word))
        else $error("stalled result word changed");

    // An accepted frame starts its run at word zero in the next cycle.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid && (m_word_index == 2'd0))
        else $error("frame run did not start at word zero");

    // Words of one run follow each other in index order.
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=> m_valid
            && (m_word_index == 2'($past(m_word_index) + 2'd1)))
        else $error("result word out of order");

    // The advance flag is the same on every word of a run.
    a_adv_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=> m_advanced == $past(m_advanced))
        else $error("advance flag changed within a frame run");

    // No new frame is taken while a run is still short of its last word.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_ready && m_last_word) |-> !s_ready)
        else $error("frame accepted during an unfinished run");

endmodule

bind ring_elementary_automaton_top rea_checker u_checker (.*);
`default_nettype wire

### tb/ring_word_checker.sv
// Checker that predicts the automaton's ring words and compares them with the result channel.
module ring_word_checker
    import rea_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [FRAME_W-1:0] s_frame_number,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [1:0]         m_word_index,
    input  wire logic [WORD_W-1:0]  m_cells_word,
    input  wire logic               m_advanced,
    input  wire logic               m_last_word,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [REG_W-1:0]   cfg_data,
    output int                      error_count,
    output int                      words_pending
);

    // One word of the ring as the block should present it.
    typedef struct packed {
        logic [1:0]        word_index;
        logic [WORD_W-1:0] cells_word;
        logic              advanced;
        logic              last_word;
    } ring_word_t;

    ring_word_t         expected_words[$];

    // Shadow copy of the register file.
    logic [REG_W-1:0]   rule_reg [NUM_RULES];
    logic [REG_W-1:0]   gens_reg;
    logic [REG_W-1:0]   fpg_reg;

    // Shadow copy of the automaton state.
    logic [NUM_CELLS-1:0] ring;
    logic [REG_W-1:0]     period_phase;
    logic [SLOT_W-1:0]    rule_slot;
    logic [FRAME_W-1:0]   last_advance_frame;
    logic                 has_advanced;

    int mismatches = 0;

    assign error_count = mismatches;

    initial words_pending = 0;

    // One generation of the elementary rule over the wrapped ring.
    function automatic logic [NUM_CELLS-1:0] next_generation(
        input logic [NUM_CELLS-1:0] cur,
        input logic [REG_W-1:0]     rule
    );
        logic [NUM_CELLS-1:0] nxt;
        logic [2:0]           hood;
        for (int i = 0; i < NUM_CELLS; i++) begin
            hood   = {cur[(i + NUM_CELLS - 1) % NUM_CELLS], cur[i], cur[(i + 1) % NUM_CELLS]};
            nxt[i] = rule[hood];
        end
        return nxt;
    endfunction

    // Advance the ring and step the rule period; the last generation of a period reseeds.
    task automatic advance_generation();
        logic [REG_W-1:0] period_end;
        period_end = (gens_reg == '0) ? '0 : gens_reg - 1'b1;
        ring = next_generation(ring, rule_reg[rule_slot]);
        if (period_phase >= period_end) begin
            ring         = '0;
            ring[SEED_A] = 1'b1;
            ring[SEED_B] = 1'b1;
            ring[SEED_C] = 1'b1;
            period_phase = '0;
            rule_slot    = (rule_slot == LAST_SLOT) ? '0 : rule_slot + 1'b1;
        end else begin
            period_phase = period_phase + 1'b1;
        end
    endtask

    // Decide whether a frame advances the ring, then queue the words it produces.
    task automatic predict_frame(input logic [FRAME_W-1:0] frame);
        logic              adv;
        logic [SNAP_W-1:0] padded;
        ring_word_t        word;
        adv = !has_advanced || (frame < last_advance_frame) ||
              ((frame - last_advance_frame) >= FRAME_W'(fpg_reg));
        if (adv) begin
            advance_generation();
            last_advance_frame = frame;
            has_advanced       = 1'b1;
        end
        padded                = '0;
        padded[NUM_CELLS-1:0] = ring;
        for (int k = 0; k < NUM_WORDS; k++) begin
            word.word_index = k[1:0];
            word.cells_word = padded[k*WORD_W +: WORD_W];
            word.advanced   = adv;
            word.last_word  = (k == NUM_WORDS - 1);
            expected_words.push_back(word);
        end
    endtask

    // Compare one delivered word with the oldest expectation.
    task automatic check_word();
        ring_word_t want;
        if (expected_words.size() == 0) begin
            $error("word delivered with no expectation: index %0d, cells %h",
                   m_word_index, m_cells_word);
            mismatches++;
        end else begin
            want = expected_words.pop_front();
            if (m_word_index !== want.word_index) begin
                $error("word_index: expected %0d, actual %0d", want.word_index, m_word_index);
                mismatches++;
            end
            if (m_cells_word !== want.cells_word) begin
                $error("cells_word: expected %h, actual %h", want.cells_word, m_cells_word);
                mismatches++;
            end
            if (m_advanced !== want.advanced) begin
                $error("advanced: expected %0b, actual %0b", want.advanced, m_advanced);
                mismatches++;
            end
            if (m_last_word !== want.last_word) begin
                $error("last_word: expected %0b, actual %0b", want.last_word, m_last_word);
                mismatches++;
            end
        end
    endtask

    // Follow every transaction on the three channels.
    always @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg[0]        = RULE_A_RST;
            rule_reg[1]        = RULE_B_RST;
            rule_reg[2]        = RULE_C_RST;
            rule_reg[3]        = RULE_D_RST;
            rule_reg[4]        = RULE_E_RST;
            rule_reg[5]        = RULE_F_RST;
            gens_reg           = GENS_RST;
            fpg_reg            = FPG_RST;
            ring               = '0;
            ring[SEED_A]       = 1'b1;
            period_phase       = '0;
            rule_slot          = '0;
            last_advance_frame = '0;
            has_advanced       = 1'b0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RULE_A, REG_RULE_B, REG_RULE_C,
                    REG_RULE_D, REG_RULE_E, REG_RULE_F: rule_reg[cfg_index] = cfg_data;
                    REG_GENS: gens_reg = cfg_data;
                    REG_FPG:  fpg_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                check_word();
            end
            if (s_valid && s_ready) begin
                predict_frame(s_frame_number);
            end
        end
        words_pending <= expected_words.size();
    end

endmodule

### tb/ring_elementary_automaton_top_tb.sv
// Testbench top for the ring elementary automaton: clock, reset, stimulus and verdict.
module ring_elementary_automaton_top_tb;
    import rea_pkg::*;

    localparam int HOLD_CYCLES = 64;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [FRAME_W-1:0] s_frame_number = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [1:0]         m_word_index;
    logic [WORD_W-1:0]  m_cells_word;
    logic               m_advanced;
    logic               m_last_word;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    cfg_reg_t           cfg_index      = REG_RULE_A;
    logic [REG_W-1:0]   cfg_data       = '0;

    int                 error_count;
    int                 words_pending;

    // Idle rates in percent for the frame sender and the word receiver.
    int                 s_idle_pct   = 30;
    int                 m_idle_pct   = 30;
    logic               hold_results = 1'b0;
    logic [FRAME_W-1:0] frame_clock  = '0;

    ring_elementary_automaton_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word_index   (m_word_index),
        .m_cells_word   (m_cells_word),
        .m_advanced     (m_advanced),
        .m_last_word    (m_last_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ring_word_checker u_word_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word_index   (m_word_index),
        .m_cells_word   (m_cells_word),
        .m_advanced     (m_advanced),
        .m_last_word    (m_last_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .words_pending  (words_pending)
    );

    always #10 aclk = ~aclk;

    // Offer one frame, idling at random first, and wait for its transaction.
    task automatic send_frame(input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_frame_number <= frame;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering frames until every predicted word has been delivered.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    // Write all eight registers in index order.
    task automatic program_regs(
        input logic [REG_W-1:0] rule_a,
        input logic [REG_W-1:0] rule_b,
        input logic [REG_W-1:0] rule_c,
        input logic [REG_W-1:0] rule_d,
        input logic [REG_W-1:0] rule_e,
        input logic [REG_W-1:0] rule_f,
        input logic [REG_W-1:0] gens,
        input logic [REG_W-1:0] fpg
    );
        logic [REG_W-1:0] plan [8];
        plan[REG_RULE_A] = rule_a;
        plan[REG_RULE_B] = rule_b;
        plan[REG_RULE_C] = rule_c;
        plan[REG_RULE_D] = rule_d;
        plan[REG_RULE_E] = rule_e;
        plan[REG_RULE_F] = rule_f;
        plan[REG_GENS]   = gens;
        plan[REG_FPG]    = fpg;
        for (int i = 0; i <= int'(REG_FPG); i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= plan[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly a frame counter creeping forward, with some step-backs and jumps.
    function automatic logic [FRAME_W-1:0] next_frame();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            frame_clock = frame_clock + FRAME_W'($urandom_range(0, 3));
        end else if (pick < 90) begin
            frame_clock = frame_clock - FRAME_W'($urandom_range(1, 20));
        end else begin
            frame_clock = FRAME_W'($urandom);
        end
        return frame_clock;
    endfunction

    // Word receiver: random backpressure, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #4_000_000;
        $display("ring_elementary_automaton_top_tb: errors");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int               pick;
        logic [REG_W-1:0] gens_pick;
        logic [REG_W-1:0] fpg_pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: first frame, equal frame, step back, frame extremes.
        send_frame(31'd0);
        send_frame(31'd3);
        send_frame(31'd5);
        send_frame(31'd5);
        send_frame(31'd4);
        send_frame(31'd8);
        send_frame(31'd9);
        send_frame(31'h7FFF_FFFF);
        send_frame(31'd0);
        send_frame(31'h2AAA_AAAA);
        send_frame(31'h5555_5555);
        send_frame(31'h5555_5559);
        wait_for_results();

        // Zero period and zero frame spacing: every frame advances and reseeds.
        program_regs(8'd0, 8'd255, 8'd30, 8'd110, 8'd60, 8'd105, 8'd0, 8'd0);
        frame_clock = 31'h5555_555A;
        send_frame(frame_clock);
        send_frame(frame_clock);
        send_frame(frame_clock + 31'd1);
        send_frame(frame_clock);
        send_frame(frame_clock + 31'd2);
        wait_for_results();

        // Largest period and spacing: two frames that both fall short of the spacing.
        program_regs(8'd255, 8'd0, 8'd150, 8'd90, 8'd22, 8'd18, 8'd255, 8'd255);
        send_frame(frame_clock + 31'd254);
        frame_clock = frame_clock + 31'd255;
        send_frame(frame_clock);
        wait_for_results();

        // Period shortened while running: the next advance must reseed at once.
        program_regs(8'd30, 8'd45, 8'd73, 8'd110, 8'd184, 8'd57, 8'd200, 8'd1);
        repeat (5) begin
            frame_clock = frame_clock + 31'd1;
            send_frame(frame_clock);
        end
        wait_for_results();
        program_regs(8'd30, 8'd45, 8'd73, 8'd110, 8'd184, 8'd57, 8'd2, 8'd1);
        frame_clock = frame_clock + 31'd1;
        send_frame(frame_clock);
        frame_clock = frame_clock + 31'd1;
        send_frame(frame_clock);
        wait_for_results();

        // Random settings, each followed by a run of frames.
        for (int phase_no = 0; phase_no < 6; phase_no++) begin
            pick      = $urandom_range(99);
            gens_pick = (pick < 10) ? 8'd0 :
                        (pick < 20) ? 8'd255 : REG_W'($urandom_range(1, 8));
            pick      = $urandom_range(99);
            fpg_pick  = (pick < 15) ? 8'd255 : REG_W'($urandom_range(0, 4));
            program_regs(REG_W'($urandom_range(255)), REG_W'($urandom_range(255)),
                         REG_W'($urandom_range(255)), REG_W'($urandom_range(255)),
                         REG_W'($urandom_range(255)), REG_W'($urandom_range(255)),
                         gens_pick, fpg_pick);
            if (phase_no == 1) begin
                hold_results = 1'b1;
            end
            if (phase_no == 3) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = 30;
                m_idle_pct = 30;
            end
            repeat (26) send_frame(next_frame());
            wait_for_results();
        end

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("ring_elementary_automaton_top_tb: clean");
        end else begin
            $display("ring_elementary_automaton_top_tb: errors");
        end
        $finish;
    end

endmodule
